// ===== src/kbr_pkg.sv =====
// ============================================================================
// kbr_pkg - keyboard report slot engine package
// Command codes, modifier range, register reset value and the control word
// that the sequencer hands to the row of slot cells.
// ============================================================================
`default_nettype none

package kbr_pkg;

    // default number of key slots in the report
    localparam int KBR_KEY_SLOTS = 6;

    // input command codes
    typedef enum logic [2:0] {
        CMD_PRESS   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_SEND    = 3'd3,
        CMD_CLEAR   = 3'd4
    } kbr_cmd_t;

    // modifier usage range
    localparam logic [7:0] MOD_FIRST = 8'hE0;
    localparam logic [7:0] MOD_LAST  = 8'hE7;

    // idle period after reset, in units of four frame ticks
    localparam logic [7:0] IDLE_RATE_RESET = 8'd125;

    // control word to every slot cell
    typedef struct packed {
        logic shift;   // take the neighbour's code
        logic clear;   // empty the slot
    } kbr_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/kbr_in_if.sv =====
// ============================================================================
// kbr_in_if - key event channel
// Valid/ready channel carrying one key event or command word.
// ============================================================================
`default_nettype none

interface kbr_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] keycode;
    logic       endpoint_ready;
    logic       link_configured;

    modport source (
        output valid, command, keycode, endpoint_ready, link_configured,
        input  ready
    );
    modport sink (
        input  valid, command, keycode, endpoint_ready, link_configured,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/kbr_out_if.sv =====
// ============================================================================
// kbr_out_if - report byte channel
// Valid/ready channel carrying one report byte word.
// ============================================================================
`default_nettype none

interface kbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;
    logic       last_in_report;
    logic       status;

    modport source (
        output valid, report_byte, last_in_report, status,
        input  ready
    );
    modport sink (
        input  valid, report_byte, last_in_report, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/kbr_slot_cell.sv =====
// ============================================================================
// kbr_slot_cell - one key slot
// Holds one key code; on shift takes the code handed on by its neighbour.
// ============================================================================
`default_nettype none

module kbr_slot_cell
    import kbr_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire kbr_cell_ctrl_t ctrl,
    input  wire logic [7:0]     d_in,
    output logic [7:0]          q
);

    logic [7:0] code_reg;

    // slot register: clear has priority over shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            code_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            code_reg <= d_in;
        end
    end

    assign q = code_reg;

endmodule

`default_nettype wire

// ===== src/kbr_seq.sv =====
// ============================================================================
// kbr_seq - report sequencer
// Decodes commands, keeps modifiers and idle timing, walks the slot ring for
// press/release and report output, and holds the output word register.
// ============================================================================
`default_nettype none

module kbr_seq
    import kbr_pkg::*;
#(
    parameter int KEY_SLOTS = KBR_KEY_SLOTS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    kbr_in_if.sink           key_in,
    kbr_out_if.source        report_out,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic [7:0]  head_code,
    output logic [7:0]       head_next,
    output kbr_cell_ctrl_t   cell_ctrl
);

    localparam int CNT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_SLOTS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_MOD  = 6'b000100,
        ST_RSV  = 6'b001000,
        ST_SLOT = 6'b010000,
        ST_ERR  = 6'b100000
    } state_t;

    state_t           state_reg,    state_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic             done_reg,     done_next;
    logic             op_press_reg, op_press_next;
    logic [7:0]       op_code_reg,  op_code_next;
    logic [7:0]       mod_reg,      mod_next;
    logic [1:0]       div_reg,      div_next;
    logic [7:0]       idle_cnt_reg, idle_cnt_next;
    logic [7:0]       idle_rate_reg, idle_rate_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_status_reg, out_status_next;

    logic in_acc;
    logic out_free;
    logic fire;

    assign key_in.ready = (state_reg == ST_IDLE);
    assign in_acc       = key_in.valid && key_in.ready;
    assign out_free     = !out_valid_reg || report_out.ready;

    // next state, ring control and output word load
    always_comb
    begin
        logic       is_mod;
        logic [7:0] mod_bit;
        logic [7:0] tick_cnt;
        logic       hit;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        done_next       = done_reg;
        op_press_next   = op_press_reg;
        op_code_next    = op_code_reg;
        mod_next        = mod_reg;
        div_next        = div_reg;
        idle_cnt_next   = idle_cnt_reg;
        idle_rate_next  = idle_rate_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        cell_ctrl       = '0;
        head_next       = head_code;
        fire            = 1'b0;

        is_mod   = (key_in.keycode >= MOD_FIRST) && (key_in.keycode <= MOD_LAST);
        mod_bit  = 8'b1 << key_in.keycode[2:0];
        tick_cnt = idle_cnt_reg + 8'd1;
        hit      = !done_reg && (op_press_reg ? (head_code == 8'd0)
                                              : (head_code == op_code_reg));

        // word taken downstream
        if (out_valid_reg && report_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        // register write clears the idle count, unless an accepted tick sets it in the same cycle
        if (cfg_we)
        begin
            idle_rate_next = cfg_wdata;
            idle_cnt_next  = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kbr_cmd_t'(key_in.command))
                        CMD_PRESS, CMD_RELEASE:
                        begin
                            if (key_in.keycode != 8'd0)
                            begin
                                if (is_mod)
                                begin
                                    mod_next = (key_in.command == CMD_PRESS)
                                             ? (mod_reg | mod_bit)
                                             : (mod_reg & ~mod_bit);
                                end
                                else
                                begin
                                    op_press_next = (key_in.command == CMD_PRESS);
                                    op_code_next  = key_in.keycode;
                                    cnt_next      = '0;
                                    done_next     = 1'b0;
                                    state_next    = ST_SCAN;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (key_in.link_configured && (idle_rate_reg != 8'd0))
                            begin
                                div_next = div_reg + 2'd1;
                                if ((div_next == 2'd0) && key_in.endpoint_ready)
                                begin
                                    if (tick_cnt == idle_rate_reg)
                                    begin
                                        idle_cnt_next = '0;
                                        fire          = 1'b1;
                                        state_next    = ST_MOD;
                                    end
                                    else
                                    begin
                                        idle_cnt_next = tick_cnt;
                                    end
                                end
                            end
                        end
                        CMD_SEND:
                        begin
                            if (key_in.link_configured)
                            begin
                                idle_cnt_next = '0;
                                state_next    = ST_MOD;
                            end
                            else
                            begin
                                state_next = ST_ERR;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            mod_next        = '0;
                            cell_ctrl.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // one slot per cycle passes the head; first hit is updated
            ST_SCAN:
            begin
                cell_ctrl.shift = 1'b1;
                if (hit)
                begin
                    head_next = op_press_reg ? op_code_reg : 8'd0;
                    done_next = 1'b1;
                end
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_MOD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = mod_reg;
                    out_last_next   = 1'b0;
                    out_status_next = 1'b0;
                    state_next      = ST_RSV;
                end
            end
            ST_RSV:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = 8'd0;
                    out_last_next   = 1'b0;
                    out_status_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = ST_SLOT;
                end
            end
            // head slot goes out, ring turns by one
            ST_SLOT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = head_code;
                    out_last_next   = (cnt_reg == CNT_LAST);
                    out_status_next = 1'b0;
                    cell_ctrl.shift = 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = 8'd0;
                    out_last_next   = 1'b1;
                    out_status_next = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            mod_reg       <= '0;
            div_reg       <= '0;
            idle_cnt_reg  <= '0;
            idle_rate_reg <= IDLE_RATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            mod_reg       <= mod_next;
            div_reg       <= div_next;
            idle_cnt_reg  <= idle_cnt_next;
            idle_rate_reg <= idle_rate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_press_reg   <= op_press_next;
        op_code_reg    <= op_code_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign report_out.valid          = out_valid_reg;
    assign report_out.report_byte    = out_byte_reg;
    assign report_out.last_in_report = out_last_reg;
    assign report_out.status         = out_status_reg;

`ifndef ASSERT_OFF
    // a scan lasts exactly one turn of the ring
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cnt_reg == CNT_LAST) |=> (state_reg == ST_IDLE))
        else $error("slot scan did not finish after one turn");

    // an idle expiry restarts the idle count and starts a report
    a_fire_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && fire && !cfg_we) |=> (idle_cnt_reg == 8'd0 && state_reg == ST_MOD))
        else $error("idle expiry did not restart count and report");

    // refused send gives a single flagged final word
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERR && out_free)
        |=> (out_valid_reg && out_status_reg && out_last_reg && state_reg == ST_IDLE))
        else $error("refused send word malformed");

    // an unflagged final report word only comes from the last slot
    a_last_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && out_last_next && !out_status_next && out_free)
        |-> (state_reg == ST_SLOT && cnt_reg == CNT_LAST))
        else $error("final report word from wrong place");
`endif

endmodule

`default_nettype wire

// ===== src/keyboard_report_slot_engine.sv =====
// ============================================================================
// keyboard_report_slot_engine - boot keyboard report keeper
// Modifier byte plus a ring of key slot cells; emits the report on request
// or on idle expiry.
// ============================================================================
//
//   port        dir   handshake     word
//   key_in      in    valid/ready   command, keycode, endpoint_ready,
//                                   link_configured
//   report_out  out   valid/ready   report_byte, last_in_report, status
//   cfg_we      in    write strobe  cfg_wdata -> idle_rate
//
// Modifier and clear words, and ticks that do not end the idle period, are
// done as they are taken; a refused send goes out via ST_ERR. Key press or
// release turns the ring once past the head cell. A report gives one output
// word per cycle while report_out does not stall; one ring step per slot.
// Reset clears all key state; idle_rate returns to 125.
// key_in is taken only between operations; the output register takes a new
// word only when empty or when its word is taken in that cycle.
//
`default_nettype none

module keyboard_report_slot_engine
    import kbr_pkg::*;
#(
    parameter int KEY_SLOTS = KBR_KEY_SLOTS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    kbr_in_if.sink          key_in,
    kbr_out_if.source       report_out,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    kbr_cell_ctrl_t cell_ctrl;
    logic [7:0]     head_next;
    logic [7:0]     slot_q [KEY_SLOTS];

    // sequencer
    kbr_seq #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in),
        .report_out (report_out),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_code  (slot_q[0]),
        .head_next  (head_next),
        .cell_ctrl  (cell_ctrl)
    );

    // slot ring: each cell takes its upper neighbour, the tail takes the head
    for (genvar i = 0; i < KEY_SLOTS; i++)
    begin : g_slot
        logic [7:0] d_in;

        if (i == KEY_SLOTS - 1)
        begin : g_tail
            assign d_in = head_next;
        end
        else
        begin : g_body
            assign d_in = slot_q[i + 1];
        end

        kbr_slot_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .d_in  (d_in),
            .q     (slot_q[i])
        );
    end

endmodule

`default_nettype wire

// ===== sim/keyboard_report_slot_engine_tb.sv =====
// ============================================================================
// keyboard_report_slot_engine_tb - self-checking bench for the report engine
// Drives key, tick, send and clear words into key_in with random pauses and
// takes report words with random stalls. A behavioural model of the modifier
// byte, the key slots and the idle timer works out every report word; each
// word taken from report_out is compared field by field with the oldest one
// still pending. The idle period is rewritten between phases, while idle.
// ============================================================================

module keyboard_report_slot_engine_tb
    import kbr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // commands the block has no use for
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam logic STATUS_SENT    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    localparam int REPORT_WORDS  = 2 + KBR_KEY_SLOTS;
    localparam int MAX_PAUSE     = 13;
    localparam int SETTLE_CYCLES = 2 * REPORT_WORDS + 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 7;
    localparam int PHASE_WORDS   = 40;
    localparam int RANDOM_PHASE  = 4;

    // idle period per phase; the random phase draws its own value
    localparam logic [7:0] IDLE_PLAN [PHASES] =
        '{8'd1, 8'd0, 8'd255, 8'd2, 8'd0, 8'd1, IDLE_RATE_RESET};

    // how a directed row gets its expected words
    typedef enum logic [1:0] {
        PREDICTED,
        REFUSED_WORD,
        BLANK_REPORT
    } check_kind_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  code;
        logic        endpoint_ready;
        logic        link_configured;
        check_kind_t kind;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       last_in_report;
        logic       status;
    } report_word_t;

    localparam int DIRECTED_ROWS = 25;

    // directed stimulus, starting straight after reset
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_SEND,     8'h00, 1'b1, 1'b0, REFUSED_WORD},   // link down
        '{CMD_SEND,     8'h00, 1'b0, 1'b1, BLANK_REPORT},   // empty after reset
        '{CMD_PRESS,    8'h00, 1'b1, 1'b1, PREDICTED},      // code zero
        '{CMD_PRESS,    8'hE0, 1'b1, 1'b1, PREDICTED},      // lowest modifier
        '{CMD_PRESS,    8'hE7, 1'b1, 1'b1, PREDICTED},      // highest modifier
        '{CMD_PRESS,    8'hDF, 1'b1, 1'b1, PREDICTED},      // just below range
        '{CMD_PRESS,    8'hE8, 1'b1, 1'b1, PREDICTED},      // just above range
        '{CMD_PRESS,    8'hFF, 1'b0, 1'b0, PREDICTED},
        '{CMD_PRESS,    8'h04, 1'b1, 1'b1, PREDICTED},
        '{CMD_PRESS,    8'h04, 1'b1, 1'b1, PREDICTED},      // same key twice
        '{CMD_PRESS,    8'h01, 1'b1, 1'b1, PREDICTED},      // last free slot
        '{CMD_PRESS,    8'h80, 1'b1, 1'b1, PREDICTED},      // all slots taken
        '{CMD_SEND,     8'h00, 1'b0, 1'b1, PREDICTED},
        '{CMD_RELEASE,  8'h04, 1'b1, 1'b1, PREDICTED},      // first match only
        '{CMD_RELEASE,  8'h55, 1'b1, 1'b1, PREDICTED},      // not held
        '{CMD_RELEASE,  8'h00, 1'b1, 1'b1, PREDICTED},      // code zero
        '{CMD_RELEASE,  8'hE0, 1'b1, 1'b1, PREDICTED},
        '{CMD_PRESS,    8'hAA, 1'b1, 1'b1, PREDICTED},      // refills the hole
        '{CMD_SEND,     8'h00, 1'b1, 1'b1, PREDICTED},
        '{CMD_SPARE_LO, 8'h3C, 1'b1, 1'b1, PREDICTED},
        '{CMD_SPARE_HI, 8'hC3, 1'b0, 1'b0, PREDICTED},
        '{CMD_TICK,     8'h00, 1'b1, 1'b0, PREDICTED},      // link down, no count
        '{CMD_TICK,     8'h00, 1'b0, 1'b1, PREDICTED},
        '{CMD_CLEAR,    8'h00, 1'b1, 1'b1, PREDICTED},
        '{CMD_SEND,     8'h00, 1'b1, 1'b1, BLANK_REPORT}    // empty after clear
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    kbr_in_if  key_in_bus ();
    kbr_out_if report_bus ();

    keyboard_report_slot_engine #(
        .KEY_SLOTS (KBR_KEY_SLOTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in_bus),
        .report_out (report_bus),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // model of the report state
    logic [7:0] held_mods = 8'h00;
    logic [7:0] held_codes [KBR_KEY_SLOTS] = '{default: 8'h00};
    logic [1:0] frame_phase = 2'd0;
    logic [7:0] idle_count = 8'd0;
    logic [7:0] idle_period = IDLE_RATE_RESET;

    report_word_t pending_words [$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           steady = 1'b0;     // both sides run without pauses

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("keyboard_report_slot_engine_tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int draw_pause();
        return steady ? 0 : $urandom_range(0, MAX_PAUSE);
    endfunction

    // queue one report run: modifiers, reserved zero, slots
    task automatic queue_report(input bit blank);
        report_word_t w;
        for (int i = 0; i < REPORT_WORDS; i++)
        begin
            if (blank || i == 1)
                w.report_byte = 8'h00;
            else if (i == 0)
                w.report_byte = held_mods;
            else
                w.report_byte = held_codes[i - 2];
            w.last_in_report = (i == REPORT_WORDS - 1);
            w.status = STATUS_SENT;
            pending_words.push_back(w);
        end
    endtask

    // press or release against the modifier byte and the slots
    task automatic update_keys(input bit press, input logic [7:0] code);
        bit done;
        done = 1'b0;
        if (code == 8'h00)
            return;
        if (code >= MOD_FIRST && code <= MOD_LAST)
        begin
            if (press)
                held_mods = held_mods | (8'h01 << code[2:0]);
            else
                held_mods = held_mods & ~(8'h01 << code[2:0]);
            return;
        end
        for (int i = 0; i < KBR_KEY_SLOTS; i++)
        begin
            if (!done)
            begin
                if (press && held_codes[i] == 8'h00)
                begin
                    held_codes[i] = code;
                    done = 1'b1;
                end
                else if (!press && held_codes[i] == code)
                begin
                    held_codes[i] = 8'h00;
                    done = 1'b1;
                end
            end
        end
    endtask

    // advance the model by one accepted word; keep=0 drops its report words
    task automatic apply_key_word(input logic [2:0] cmd, input logic [7:0] code,
                                  input logic er, input logic lc, input bit keep);
        report_word_t refused;
        refused = '{8'h00, 1'b1, STATUS_REFUSED};
        case (cmd)
            CMD_PRESS:   update_keys(1'b1, code);
            CMD_RELEASE: update_keys(1'b0, code);
            CMD_TICK:
            begin
                if (lc && idle_period != 8'd0)
                begin
                    frame_phase = frame_phase + 2'd1;
                    if (frame_phase == 2'd0 && er)
                    begin
                        idle_count = idle_count + 8'd1;
                        if (idle_count == idle_period)
                        begin
                            idle_count = 8'd0;
                            if (keep)
                                queue_report(1'b0);
                        end
                    end
                end
            end
            CMD_SEND:
            begin
                if (!lc)
                begin
                    if (keep)
                        pending_words.push_back(refused);
                end
                else
                begin
                    idle_count = 8'd0;
                    if (keep)
                        queue_report(1'b0);
                end
            end
            CMD_CLEAR:
            begin
                held_mods = 8'h00;
                foreach (held_codes[i])
                    held_codes[i] = 8'h00;
            end
            default: ;
        endcase
    endtask

    // offer one word on key_in and wait for it to be taken
    task automatic post_word(input logic [2:0] cmd, input logic [7:0] code,
                             input logic er, input logic lc, input check_kind_t kind);
        int gap;
        report_word_t refused;
        refused = '{8'h00, 1'b1, STATUS_REFUSED};
        gap = draw_pause();
        if (gap > 0)
        begin
            key_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_in_bus.valid           <= 1'b1;
        key_in_bus.command         <= cmd;
        key_in_bus.keycode         <= code;
        key_in_bus.endpoint_ready  <= er;
        key_in_bus.link_configured <= lc;
        do
            @(posedge clk);
        while (key_in_bus.ready !== 1'b1);
        apply_key_word(cmd, code, er, lc, kind == PREDICTED);
        if (kind == REFUSED_WORD)
            pending_words.push_back(refused);
        else if (kind == BLANK_REPORT)
            queue_report(1'b1);
    endtask

    // rewrite idle_rate once the block has gone quiet
    task automatic set_idle_period(input logic [7:0] rate);
        key_in_bus.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wdata <= rate;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        idle_period = rate;
        idle_count  = 8'd0;
    endtask

    // report_out: fresh stall drawn for every word
    initial
    begin : take_words
        int stall;
        report_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_pause();
            if (stall > 0)
            begin
                report_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            report_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (report_bus.valid !== 1'b1);
        end
    end

    // compare every word taken with the oldest pending one
    always @(posedge clk)
    begin : check_words
        report_word_t due;
        if (rst_n && report_bus.valid && report_bus.ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("unexpected word byte=%02h last=%0b status=%0b",
                                          report_bus.report_byte,
                                          report_bus.last_in_report, report_bus.status));
            else
            begin
                due = pending_words.pop_front();
                if (report_bus.report_byte !== due.report_byte)
                    report_mismatch($sformatf("report_byte %02h, wanted %02h",
                                              report_bus.report_byte, due.report_byte));
                if (report_bus.last_in_report !== due.last_in_report)
                    report_mismatch($sformatf("last_in_report %0b, wanted %0b",
                                              report_bus.last_in_report,
                                              due.last_in_report));
                if (report_bus.status !== due.status)
                    report_mismatch($sformatf("status %0b, wanted %0b",
                                              report_bus.status, due.status));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int          roll;
        int          drain_cycles;
        logic [2:0]  cmd;
        logic [7:0]  code;
        logic [7:0]  rate;
        logic        er;
        logic        lc;

        rst_n                      <= 1'b0;
        cfg_we                     <= 1'b0;
        cfg_wdata                  <= 8'h00;
        key_in_bus.valid           <= 1'b0;
        key_in_bus.command         <= CMD_PRESS;
        key_in_bus.keycode         <= 8'h00;
        key_in_bus.endpoint_ready  <= 1'b0;
        key_in_bus.link_configured <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (DIRECTED[i])
            post_word(DIRECTED[i].cmd, DIRECTED[i].code, DIRECTED[i].endpoint_ready,
                      DIRECTED[i].link_configured, DIRECTED[i].kind);

        // random phases, one idle period each
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == RANDOM_PHASE)
                rate = 8'($urandom_range(0, 255));
            else
                rate = IDLE_PLAN[phase];
            set_idle_period(rate);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                steady = ((n / 10) % 4 == 3);
                roll = $urandom_range(0, 99);
                code = 8'($urandom_range(0, 255));
                er   = ($urandom_range(0, 99) < 85);
                lc   = ($urandom_range(0, 99) < 90);
                if (roll < 28)
                begin
                    cmd  = CMD_PRESS;
                    roll = $urandom_range(0, 99);
                    if (roll < 25)
                        code = MOD_FIRST + 8'($urandom_range(0, 7));
                    else if (roll < 30)
                        code = 8'h00;
                end
                else if (roll < 50)
                begin
                    cmd  = CMD_RELEASE;
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        code = held_codes[$urandom_range(0, KBR_KEY_SLOTS - 1)];
                    else if (roll < 65)
                        code = MOD_FIRST + 8'($urandom_range(0, 7));
                end
                else if (roll < 78)
                    cmd = CMD_TICK;
                else if (roll < 90)
                    cmd = CMD_SEND;
                else if (roll < 94)
                    cmd = CMD_CLEAR;
                else if (roll < 96)
                    cmd = CMD_SPARE_LO;
                else if (roll < 98)
                    cmd = CMD_SPARE_MID;
                else
                    cmd = CMD_SPARE_HI;
                post_word(cmd, code, er, lc, PREDICTED);
            end
        end
        steady = 1'b0;
        key_in_bus.valid <= 1'b0;

        // let the last report words drain
        drain_cycles = 0;
        while (pending_words.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_words.size()));

        if (mismatches == 0)
            $display("keyboard_report_slot_engine_tb: done, clean");
        else
            $display("keyboard_report_slot_engine_tb: done, errors");
        $finish;
    end

endmodule
